/* rtl/core/kmst_pkg.sv */
`default_nettype none
package kmst_pkg;

  localparam int ID_W       = 16;
  localparam int LINE_W     = 16;
  localparam int HANDLE_W   = 16;
  localparam int OP_W       = 3;
  localparam int STATUS_W   = 2;
  localparam int SLOT_OUT_W = 4;
  localparam int BYTE_BITS  = 8;
  localparam int BIT_SEL_W  = 3;
  localparam int ROW_SRC_W  = ID_W - BIT_SEL_W;

  localparam int SLOTS_DEF  = 16;
  localparam int LINES_DEF  = 4;
  localparam int PBYTES_DEF = 32;

  localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
  localparam logic [OP_W-1:0] OP_GET    = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
  localparam logic [OP_W-1:0] OP_QUERY  = 3'd3;
  localparam logic [OP_W-1:0] OP_EMPTY  = 3'd4;
  localparam logic [OP_W-1:0] OP_FULL   = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OOB = 2'd2;

  typedef struct packed {
    logic valid;
    logic key_hit;
    logic free_hit;
  } kmst_tok_t;

  typedef struct packed {
    logic            clear;
    logic            wr;
    logic            used;
    logic [ID_W-1:0] key;
  } kmst_cmd_t;

endpackage
`default_nettype wire

/* rtl/core/kmst_cell.sv */
`default_nettype none
module kmst_cell #(
  parameter int SLOT_W = 4
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire  [SLOT_W-1:0]            cell_idx,
  input  wire  [kmst_pkg::ID_W-1:0]    srch_id,
  input  kmst_pkg::kmst_cmd_t          cmd,
  input  kmst_pkg::kmst_tok_t          tok_in,
  input  wire  [SLOT_W-1:0]            key_slot_in,
  input  wire  [SLOT_W-1:0]            free_slot_in,
  output kmst_pkg::kmst_tok_t          tok_out,
  output logic [SLOT_W-1:0]            key_slot_out,
  output logic [SLOT_W-1:0]            free_slot_out
);

  logic                       used_r;
  logic [kmst_pkg::ID_W-1:0]  key_r;
  kmst_pkg::kmst_tok_t        tok_r;
  logic [SLOT_W-1:0]          key_slot_r;
  logic [SLOT_W-1:0]          free_slot_r;
  logic                       match;

  assign match = used_r && (key_r == srch_id);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
      tok_r  <= '0;
    end else begin
      if (cmd.clear) begin
        used_r <= 1'b0;
      end else if (cmd.wr) begin
        used_r <= cmd.used;
      end
      tok_r.valid <= tok_in.valid;
      if (tok_in.valid) begin
        tok_r.key_hit  <= tok_in.key_hit | match;
        tok_r.free_hit <= tok_in.free_hit | !used_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      key_r <= cmd.key;
    end
    if (tok_in.valid) begin
      key_slot_r  <= tok_in.key_hit ? key_slot_in : cell_idx;
      free_slot_r <= tok_in.free_hit ? free_slot_in : cell_idx;
    end
  end

  assign tok_out       = tok_r;
  assign key_slot_out  = key_slot_r;
  assign free_slot_out = free_slot_r;

endmodule
`default_nettype wire

/* rtl/core/kmst_row_mod.sv */
`default_nettype none
module kmst_row_mod #(
  parameter int PRESENCE_BYTES = kmst_pkg::PBYTES_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              start,
  input  wire  [kmst_pkg::ROW_SRC_W-1:0]   value,
  output logic                             done,
  output logic [((PRESENCE_BYTES > 1) ? $clog2(PRESENCE_BYTES) : 1)-1:0] row
);

  localparam int ROW_W = (PRESENCE_BYTES > 1) ? $clog2(PRESENCE_BYTES) : 1;
  localparam int VAL_W = kmst_pkg::ROW_SRC_W;
  localparam int RCP_W = VAL_W + 1;
  localparam int PRD_W = VAL_W + RCP_W;
  localparam int REM_W = VAL_W + 1;
  localparam logic [RCP_W-1:0] RECIP = RCP_W'((1 << VAL_W) / PRESENCE_BYTES);
  localparam logic [REM_W-1:0] PV    = REM_W'(PRESENCE_BYTES);

  logic [2:0]       stage_r;
  logic             done_r;
  logic [VAL_W-1:0] val_r;
  logic [RCP_W-1:0] quot_r;
  logic [REM_W-1:0] part_r;
  logic [ROW_W-1:0] rem_r;
  logic [PRD_W-1:0] prod;
  logic [REM_W-1:0] back_prod;
  logic [REM_W-1:0] part_nxt;
  logic [REM_W-1:0] rem_nxt;

  // The quotient taken from the reciprocal is at most one low, so one
  // subtraction corrects the remainder.
  assign prod      = PRD_W'(val_r) * PRD_W'(RECIP);
  assign back_prod = REM_W'(quot_r) * PV;
  assign part_nxt  = {1'b0, val_r} - back_prod;
  assign rem_nxt   = (part_r >= PV) ? (part_r - PV) : part_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= '0;
      done_r  <= 1'b0;
    end else if (start) begin
      stage_r <= 3'b001;
      done_r  <= 1'b0;
    end else begin
      stage_r <= {stage_r[1:0], 1'b0};
      if (stage_r[2]) begin
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val_r <= value;
    end
    if (stage_r[0]) begin
      quot_r <= prod[PRD_W-1:VAL_W];
    end
    if (stage_r[1]) begin
      part_r <= part_nxt;
    end
    if (stage_r[2]) begin
      rem_r <= rem_nxt[ROW_W-1:0];
    end
  end

  assign done = done_r;
  assign row  = rem_r;

endmodule
`default_nettype wire

/* rtl/core/keyed_message_slot_table.sv */
// An item's result is loaded in S_READ once its search and its presence row are both done.
// Empty all clears the slot cells, then sweeps the bitmap, one presence row cleared per cycle.
// One item is in flight at a time and the next transfer can be taken in the cycle after the
// result is loaded; the search token walks the slot chain.
// After reset a clearing pass zeroes the line store and presence bitmap; no item is taken
// until it ends.
`default_nettype none
module keyed_message_slot_table #(
  parameter int SLOTS          = kmst_pkg::SLOTS_DEF,
  parameter int LINES_PER_SLOT = kmst_pkg::LINES_DEF,
  parameter int PRESENCE_BYTES = kmst_pkg::PBYTES_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire  [kmst_pkg::OP_W-1:0]          in_op,
  input  wire  [kmst_pkg::ID_W-1:0]          in_msg_id,
  input  wire  [kmst_pkg::LINE_W-1:0]        in_line_no,
  input  wire  [kmst_pkg::HANDLE_W-1:0]      in_text_handle,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic [kmst_pkg::STATUS_W-1:0]      out_status,
  output logic [kmst_pkg::SLOT_OUT_W-1:0]    out_slot_index,
  output logic [kmst_pkg::HANDLE_W-1:0]      out_line_handle,
  output logic                               out_is_full
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int NLINES = SLOTS * LINES_PER_SLOT;
  localparam int LA_W   = $clog2(NLINES);
  localparam int LN_W   = (LINES_PER_SLOT > 1) ? $clog2(LINES_PER_SLOT) : 1;
  localparam int ROW_W  = (PRESENCE_BYTES > 1) ? $clog2(PRESENCE_BYTES) : 1;
  localparam int CLR_N  = (NLINES > PRESENCE_BYTES) ? NLINES : PRESENCE_BYTES;
  localparam int CLR_W  = $clog2(CLR_N);
  localparam int BB     = kmst_pkg::BYTE_BITS;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SEARCH,
    S_SWEEP,
    S_READ
  } state_t;

  state_t                          state_r, state_nxt;
  logic [CLR_W-1:0]                cnt_r, cnt_nxt;
  logic [kmst_pkg::OP_W-1:0]       op_r;
  logic [kmst_pkg::ID_W-1:0]       id_r;
  logic [LN_W-1:0]                 line_lo_r;
  logic                            line_ok_r;
  logic [kmst_pkg::HANDLE_W-1:0]   handle_r;
  logic                            launch_r;
  logic                            srch_done_r;
  logic                            out_valid_r;
  logic [kmst_pkg::STATUS_W-1:0]   out_status_r;
  logic [SLOT_W-1:0]               out_slot_r;
  logic [kmst_pkg::HANDLE_W-1:0]   out_lh_r;
  logic                            out_full_r;

  logic [kmst_pkg::HANDLE_W-1:0]   line_mem [NLINES];
  logic [BB-1:0]                   pres_mem [PRESENCE_BYTES];
  logic [kmst_pkg::HANDLE_W-1:0]   line_rd_r;
  logic [BB-1:0]                   pres_rd_r;

  logic                            accept;
  logic                            out_free;
  logic                            out_load;
  logic                            mod_done;
  logic [ROW_W-1:0]                row;
  logic                            rd_en;
  logic                            line_we;
  logic [LA_W-1:0]                 line_wa;
  logic [LA_W-1:0]                 line_ra;
  logic [kmst_pkg::HANDLE_W-1:0]   line_wd;
  logic                            pres_we;
  logic [ROW_W-1:0]                pres_wa;
  logic [BB-1:0]                   pres_wd;
  logic [BB-1:0]                   bit_mask;
  logic                            pbit;
  logic                            add_hit;
  logic [SLOT_W-1:0]               add_slot;
  logic                            cell_clear;
  logic                            cell_wr;
  logic                            cell_used;
  logic [SLOT_W-1:0]               cell_slot;
  logic [kmst_pkg::STATUS_W-1:0]   res_status;
  logic [SLOT_W-1:0]               res_slot;
  logic [kmst_pkg::HANDLE_W-1:0]   res_lh;
  logic                            res_full;
  logic [SLOT_W+kmst_pkg::SLOT_OUT_W-1:0] slot_ext;

  kmst_pkg::kmst_tok_t             tok   [SLOTS+1];
  logic [SLOT_W-1:0]               kslot [SLOTS+1];
  logic [SLOT_W-1:0]               fslot [SLOTS+1];
  logic [SLOTS:0]                  tok_vld;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  kmst_row_mod #(
    .PRESENCE_BYTES(PRESENCE_BYTES)
  ) u_row_mod (
    .clk  (clk),
    .rst_n(rst_n),
    .start(accept),
    .value(in_msg_id[kmst_pkg::ID_W-1:kmst_pkg::BIT_SEL_W]),
    .done (mod_done),
    .row  (row)
  );

  assign tok[0]   = '{valid: launch_r, key_hit: 1'b0, free_hit: 1'b0};
  assign kslot[0] = '0;
  assign fslot[0] = '0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    kmst_pkg::kmst_cmd_t cmd;

    assign cmd = '{clear: cell_clear,
                   wr:    cell_wr && (cell_slot == SLOT_W'(i)),
                   used:  cell_used,
                   key:   id_r};

    kmst_cell #(
      .SLOT_W(SLOT_W)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .cell_idx     (SLOT_W'(i)),
      .srch_id      (id_r),
      .cmd          (cmd),
      .tok_in       (tok[i]),
      .key_slot_in  (kslot[i]),
      .free_slot_in (fslot[i]),
      .tok_out      (tok[i+1]),
      .key_slot_out (kslot[i+1]),
      .free_slot_out(fslot[i+1])
    );
  end

  for (genvar j = 0; j <= SLOTS; j++) begin : g_vld
    assign tok_vld[j] = tok[j].valid;
  end

  assign pbit     = pres_rd_r[id_r[kmst_pkg::BIT_SEL_W-1:0]];
  assign bit_mask = BB'(1) << id_r[kmst_pkg::BIT_SEL_W-1:0];
  assign add_hit  = pbit ? tok[SLOTS].key_hit : tok[SLOTS].free_hit;
  assign add_slot = pbit ? kslot[SLOTS] : fslot[SLOTS];
  assign line_ra  = LA_W'(kslot[SLOTS]) * LA_W'(LINES_PER_SLOT) + LA_W'(line_lo_r);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    rd_en      = 1'b0;
    out_load   = 1'b0;
    cell_clear = 1'b0;
    cell_wr    = 1'b0;
    cell_used  = 1'b0;
    cell_slot  = add_slot;
    line_we    = 1'b0;
    line_wa    = LA_W'(add_slot) * LA_W'(LINES_PER_SLOT) + LA_W'(line_lo_r);
    line_wd    = handle_r;
    pres_we    = 1'b0;
    pres_wa    = row;
    pres_wd    = pres_rd_r | bit_mask;
    res_status = kmst_pkg::ST_NO;
    res_slot   = '0;
    res_lh     = '0;
    res_full   = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        pres_we = ({1'b0, cnt_r} < (CLR_W + 1)'(PRESENCE_BYTES));
        pres_wa = cnt_r[ROW_W-1:0];
        pres_wd = '0;
        line_we = ({1'b0, cnt_r} < (CLR_W + 1)'(NLINES));
        line_wa = cnt_r[LA_W-1:0];
        line_wd = '0;
        if (cnt_r == CLR_W'(CLR_N - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_op == kmst_pkg::OP_EMPTY) begin
            cell_clear = 1'b1;
            cnt_nxt    = '0;
            state_nxt  = S_SWEEP;
          end else begin
            state_nxt = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (srch_done_r && mod_done) begin
          rd_en     = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_SWEEP: begin
        pres_we = 1'b1;
        pres_wa = cnt_r[ROW_W-1:0];
        pres_wd = '0;
        if (cnt_r == CLR_W'(PRESENCE_BYTES - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_READ;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_READ: begin
        case (op_r)
          kmst_pkg::OP_ADD: begin
            if (add_hit && line_ok_r) begin
              res_status = kmst_pkg::ST_OK;
              res_slot   = add_slot;
              pres_we    = out_free;
              cell_wr    = out_free;
              cell_used  = 1'b1;
              line_we    = out_free;
            end
          end
          kmst_pkg::OP_GET: begin
            if (tok[SLOTS].key_hit) begin
              res_slot = kslot[SLOTS];
              if (line_ok_r) begin
                res_status = kmst_pkg::ST_OK;
                res_lh     = line_rd_r;
              end else begin
                res_status = kmst_pkg::ST_OOB;
              end
            end
          end
          kmst_pkg::OP_REMOVE: begin
            if (pbit) begin
              pres_we = out_free;
              pres_wd = pres_rd_r & ~bit_mask;
              if (tok[SLOTS].key_hit) begin
                res_status = kmst_pkg::ST_OK;
                res_slot   = kslot[SLOTS];
                cell_wr    = out_free;
                cell_slot  = kslot[SLOTS];
              end
            end
          end
          kmst_pkg::OP_QUERY: begin
            res_status = pbit ? kmst_pkg::ST_OK : kmst_pkg::ST_NO;
          end
          kmst_pkg::OP_EMPTY: begin
            res_status = kmst_pkg::ST_OK;
          end
          kmst_pkg::OP_FULL: begin
            res_status = kmst_pkg::ST_OK;
            res_full   = !tok[SLOTS].free_hit;
          end
          default: begin
            res_status = kmst_pkg::ST_NO;
          end
        endcase
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      launch_r    <= 1'b0;
      srch_done_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      launch_r <= accept && (in_op != kmst_pkg::OP_EMPTY);
      if (accept) begin
        srch_done_r <= 1'b0;
      end else if (tok[SLOTS].valid) begin
        srch_done_r <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (accept) begin
      op_r      <= in_op;
      id_r      <= in_msg_id;
      line_lo_r <= in_line_no[LN_W-1:0];
      line_ok_r <= (in_line_no < kmst_pkg::LINE_W'(LINES_PER_SLOT));
      handle_r  <= in_text_handle;
    end
    if (out_load) begin
      out_status_r <= res_status;
      out_slot_r   <= res_slot;
      out_lh_r     <= res_lh;
      out_full_r   <= res_full;
    end
  end

  always_ff @(posedge clk) begin
    if (line_we) begin
      line_mem[line_wa] <= line_wd;
    end
    if (rd_en && line_ok_r) begin
      line_rd_r <= line_mem[line_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (pres_we) begin
      pres_mem[pres_wa] <= pres_wd;
    end
    if (rd_en) begin
      pres_rd_r <= pres_mem[row];
    end
  end

  assign slot_ext        = {{kmst_pkg::SLOT_OUT_W{1'b0}}, out_slot_r};
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_slot_index  = slot_ext[kmst_pkg::SLOT_OUT_W-1:0];
  assign out_line_handle = out_lh_r;
  assign out_is_full     = out_full_r;

`ifndef SYNTHESIS
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vld))
    else $error("More than one search token in the slot chain.");

  a_no_write_during_search: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_wr || cell_clear) |-> (tok_vld == '0))
    else $error("Slot cell written while a search is in the chain.");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !(out_valid_r && out_stall))
    else $error("Result register overwritten while its transfer is stalled.");
`endif

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
`default_nettype none
module tb;
  import kmst_pkg::*;

  localparam int NSLOTS   = SLOTS_DEF;
  localparam int NLINES   = LINES_DEF;
  localparam int NPBYTES  = PBYTES_DEF;
  localparam int NPBITS   = NPBYTES * BYTE_BITS;
  localparam int IDLE_PCT = 12;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int ID_POOL  = 24;

  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [SLOT_OUT_W-1:0] slot;
    logic [HANDLE_W-1:0]   handle;
    logic                  full;
  } table_reply_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [OP_W-1:0]       in_op;
  logic [ID_W-1:0]       in_msg_id;
  logic [LINE_W-1:0]     in_line_no;
  logic [HANDLE_W-1:0]   in_text_handle;
  logic                  out_valid;
  logic                  out_stall;
  logic [STATUS_W-1:0]   out_status;
  logic [SLOT_OUT_W-1:0] out_slot_index;
  logic [HANDLE_W-1:0]   out_line_handle;
  logic                  out_is_full;

  bit                    tab_used [NSLOTS];
  logic [ID_W-1:0]       tab_key [NSLOTS];
  logic [HANDLE_W-1:0]   tab_lines [NSLOTS*NLINES];
  bit                    tab_present [NPBITS];

  table_reply_t          awaited_replies [$];
  logic [ID_W-1:0]       id_pool [ID_POOL];
  int                    err_count;
  bit                    idle_on;
  bit                    rx_hold_req;

  keyed_message_slot_table u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_msg_id      (in_msg_id),
    .in_line_no     (in_line_no),
    .in_text_handle (in_text_handle),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_slot_index (out_slot_index),
    .out_line_handle(out_line_handle),
    .out_is_full    (out_is_full)
  );

  always #6 clk = ~clk;

  function automatic int presence_bit(logic [ID_W-1:0] id);
    return ((int'(id) / BYTE_BITS) % NPBYTES) * BYTE_BITS + (int'(id) % BYTE_BITS);
  endfunction

  function automatic bit lookup_key(logic [ID_W-1:0] id, output int slot);
    slot = 0;
    for (int i = 0; i < NSLOTS; i++) begin
      if (tab_used[i] && tab_key[i] == id) begin
        slot = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit lookup_free(output int slot);
    slot = 0;
    for (int i = 0; i < NSLOTS; i++) begin
      if (!tab_used[i]) begin
        slot = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic table_reply_t predict_table_reply(logic [OP_W-1:0] op,
      logic [ID_W-1:0] id, logic [LINE_W-1:0] line, logic [HANDLE_W-1:0] handle);
    table_reply_t r;
    int b;
    int s;
    bit hit;
    r = '0;
    r.status = ST_NO;
    b = presence_bit(id);
    s = 0;
    case (op)
      OP_ADD: begin
        hit = tab_present[b] ? lookup_key(id, s) : lookup_free(s);
        if (hit && line < NLINES) begin
          tab_present[b] = 1'b1;
          tab_key[s] = id;
          tab_used[s] = 1'b1;
          tab_lines[s*NLINES + int'(line)] = handle;
          r.status = ST_OK;
          r.slot = s[SLOT_OUT_W-1:0];
        end
      end
      OP_GET: begin
        if (lookup_key(id, s)) begin
          r.slot = s[SLOT_OUT_W-1:0];
          if (line < NLINES) begin
            r.handle = tab_lines[s*NLINES + int'(line)];
            r.status = ST_OK;
          end else begin
            r.status = ST_OOB;
          end
        end
      end
      OP_REMOVE: begin
        if (tab_present[b]) begin
          tab_present[b] = 1'b0;
          if (lookup_key(id, s)) begin
            tab_used[s] = 1'b0;
            tab_key[s] = '0;
            r.status = ST_OK;
            r.slot = s[SLOT_OUT_W-1:0];
          end
        end
      end
      OP_QUERY: r.status = tab_present[b] ? ST_OK : ST_NO;
      OP_EMPTY: begin
        for (int i = 0; i < NSLOTS; i++) begin
          tab_used[i] = 1'b0;
          tab_key[i] = '0;
        end
        for (int i = 0; i < NPBITS; i++) tab_present[i] = 1'b0;
        r.status = ST_OK;
      end
      OP_FULL: begin
        r.full = !lookup_free(s);
        r.status = ST_OK;
      end
      default: r.status = ST_NO;
    endcase
    return r;
  endfunction

  task automatic send_item(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
      logic [LINE_W-1:0] line, logic [HANDLE_W-1:0] handle);
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_msg_id      <= id;
    in_line_no     <= line;
    in_text_handle <= handle;
    do @(posedge clk); while (in_stall !== 1'b0);
    awaited_replies.push_back(predict_table_reply(op, id, line, handle));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_replies.size() != 0);
  endtask

  function automatic logic [ID_W-1:0] pick_id();
    return ($urandom_range(0, 9) == 0) ? ID_W'($urandom) : id_pool[$urandom_range(0, ID_POOL-1)];
  endfunction

  function automatic logic [LINE_W-1:0] pick_line();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return LINE_W'($urandom_range(0, NLINES-1));
    if (r < 90) return LINE_W'(NLINES);
    return LINE_W'($urandom);
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 36) return OP_ADD;
    if (r < 60) return OP_GET;
    if (r < 72) return OP_REMOVE;
    if (r < 82) return OP_QUERY;
    if (r < 90) return OP_FULL;
    if (r < 93) return OP_EMPTY;
    if (r < 96) return ($urandom_range(0, 1) != 0) ? OP_SPARE_HI : OP_SPARE_LO;
    return OP_ADD;
  endfunction

  task automatic send_random(int count);
    for (int i = 0; i < count; i++) begin
      send_item(pick_op(), pick_id(), pick_line(), HANDLE_W'($urandom));
    end
  endtask

  // Ids 16'hFFFF and 16'h01FF share one presence bit.
  task automatic test_directed_ops();
    send_item(OP_FULL,   16'h0000, 16'h0000, 16'h0000);
    send_item(OP_GET,    16'h1234, 16'h0000, 16'h0000);
    send_item(OP_QUERY,  16'h1234, 16'h0000, 16'h0000);
    send_item(OP_REMOVE, 16'h1234, 16'h0000, 16'h0000);
    send_item(OP_ADD,    16'h0000, 16'h0000, 16'hFFFF);
    send_item(OP_ADD,    16'hFFFF, 16'h0003, 16'h0000);
    send_item(OP_ADD,    16'hFFFF, 16'h0004, 16'hA5A5);
    send_item(OP_GET,    16'hFFFF, 16'hFFFF, 16'h0000);
    send_item(OP_ADD,    16'h01FF, 16'h0001, 16'h5A5A);
    send_item(OP_REMOVE, 16'h01FF, 16'h0000, 16'h0000);
    send_item(OP_GET,    16'hFFFF, 16'h0003, 16'hFFFF);
    send_item(OP_ADD,    16'hFFFF, 16'h0002, 16'h1357);
    send_item(OP_SPARE_LO, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_SPARE_HI, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(OP_EMPTY,  16'h0000, 16'h0000, 16'h0000);
  endtask

  task automatic test_full_table();
    for (int i = 0; i <= NSLOTS; i++) begin
      send_item(OP_ADD, ID_W'(16'h0008 * i + 3), LINE_W'(i % NLINES), HANDLE_W'($urandom));
    end
    send_item(OP_FULL, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_GET, 16'h007B, 16'h0003, 16'h0000);
    send_item(OP_EMPTY, 16'h0000, 16'h0000, 16'h0000);
  endtask

  task automatic test_random_traffic(int count);
    send_random(count);
  endtask

  task automatic test_back_to_back(int count);
    idle_on = 1'b0;
    send_random(count);
    idle_on = 1'b1;
  endtask

  task automatic test_receiver_hold();
    rx_hold_req = 1'b1;
    send_random(30);
  endtask

  task automatic test_sender_pause();
    send_random(100);
    wait_drained();
    send_random(100);
  endtask

  // Result side: random backpressure, with a long hold when a test requests one.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        out_stall <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
      end
      out_stall <= idle_on && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    table_reply_t exp_r;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (awaited_replies.size() == 0) begin
        $error("unexpected transfer on the result channel");
        err_count++;
      end else begin
        exp_r = awaited_replies.pop_front();
        if (out_status !== exp_r.status) begin
          $error("status mismatch: expected %0d, got %0d", exp_r.status, out_status);
          err_count++;
        end
        if (out_slot_index !== exp_r.slot) begin
          $error("slot_index mismatch: expected %0d, got %0d", exp_r.slot, out_slot_index);
          err_count++;
        end
        if (out_line_handle !== exp_r.handle) begin
          $error("line_handle mismatch: expected %h, got %h", exp_r.handle, out_line_handle);
          err_count++;
        end
        if (out_is_full !== exp_r.full) begin
          $error("is_full mismatch: expected %0d, got %0d", exp_r.full, out_is_full);
          err_count++;
        end
      end
    end
  end

  initial begin
    #(12 * 1000000);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_op          = OP_ADD;
    in_msg_id      = '0;
    in_line_no     = '0;
    in_text_handle = '0;
    err_count      = 0;
    idle_on        = 1'b1;
    rx_hold_req    = 1'b0;
    for (int i = 0; i < NSLOTS; i++) begin
      tab_used[i] = 1'b0;
      tab_key[i]  = '0;
    end
    for (int i = 0; i < NSLOTS*NLINES; i++) tab_lines[i] = '0;
    for (int i = 0; i < NPBITS; i++) tab_present[i] = 1'b0;
    // A few low bytes only, so that pool ids often share a presence bit.
    for (int i = 0; i < ID_POOL; i++) begin
      id_pool[i] = {8'($urandom), 8'($urandom_range(0, 7) * 37)};
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_ops();
    test_full_table();
    test_random_traffic(900);
    test_back_to_back(300);
    test_receiver_hold();
    test_sender_pause();
    test_random_traffic(500);

    wait_drained();
    repeat (60) @(posedge clk);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
